[rtl/bpa_pkg.sv]
// ----------------------------------------------------------------------------
// bpa_pkg
// Shared types and codes of the bitmap page allocator.
// ----------------------------------------------------------------------------
package bpa_pkg;

  localparam int COUNT_W  = 13;
  localparam int ADDR_W   = 48;
  localparam int STATUS_W = 3;
  localparam int CFG_IDX_W = 2;

  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;

  localparam logic [CFG_IDX_W-1:0] REG_POOL_BASE  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PAGE_COUNT = 2'd1;

  localparam logic [STATUS_W-1:0] STAT_OK         = 3'd0;
  localparam logic [STATUS_W-1:0] STAT_POOL_EMPTY = 3'd1;
  localparam logic [STATUS_W-1:0] STAT_BAD_COUNT  = 3'd2;
  localparam logic [STATUS_W-1:0] STAT_NO_RUN     = 3'd3;
  localparam logic [STATUS_W-1:0] STAT_MISALIGNED = 3'd4;
  localparam logic [STATUS_W-1:0] STAT_OUT_BOUNDS = 3'd5;
  localparam logic [STATUS_W-1:0] STAT_IGNORED    = 3'd6;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_SCAN,
    S_FCHK,
    S_FILL,
    S_POST
  } state_t;

endpackage

[rtl/bpa_ram.sv]
// ----------------------------------------------------------------------------
// bpa_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module bpa_ram #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[rtl/bitmap_page_allocator_unit.sv]
// ----------------------------------------------------------------------------
// bitmap_page_allocator_unit
// First-fit contiguous page allocator over a used-page bitmap held in RAM.
// ----------------------------------------------------------------------------
// Input words carry an operation in in_tuser and a page count and an address
// in in_tdata. Each word gives one output word with a status and, for a
// successful allocate, the base address of the run.
// An allocate scans the map from page 0, one page per cycle through the RAM
// read port, until a free run of the requested length is found, then marks
// the run used one page per cycle through the write port. A scan that reaches
// page_count without such a run answers with STAT_NO_RUN.
// A free forms the offset from the pool base on acceptance, checks alignment
// and bounds in the next cycle and then clears count pages, one per cycle.
// One word is in work at a time; a new word is taken once the previous
// result sits in the output register, even while the receiver stalls it.
// A result that finds the output register full waits until it drains.
// Reset and every page_count write start a clearing pass over all MAX_PAGES
// entries of the map, during which no input word is taken. The user writes the
// configuration port only while the block is idle; the block does not check.
// ----------------------------------------------------------------------------
module bitmap_page_allocator_unit
  import bpa_pkg::*;
#(
  parameter int MAX_PAGES  = 4096,
  parameter int PAGE_BYTES = 4096,
  parameter int ADDR_BITS  = 48
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_tvalid,
  output logic                 in_tready,
  input  logic [63:0]          in_tdata,   // count[12:0], address[60:13]
  input  logic [0:0]           in_tuser,   // operation[0]
  output logic                 out_tvalid,
  input  logic                 out_tready,
  output logic [55:0]          out_tdata,  // status[2:0], base_address[50:3]
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [ADDR_W-1:0]    cfg_data
);

  localparam int PG_W  = $clog2(MAX_PAGES);
  localparam int IW    = PG_W + 1;
  localparam int CW    = (IW > COUNT_W) ? IW : COUNT_W;
  localparam int PB_LG = $clog2(PAGE_BYTES);
  localparam logic [63:0] ADDR_MASK = {64{1'b1}} >> (64 - ADDR_BITS);

  state_t state_r, state_nxt;

  logic [ADDR_W-1:0]   pool_base_r, pool_base_nxt;
  logic [COUNT_W-1:0]  page_count_r, page_count_nxt;
  logic [PG_W-1:0]     clr_r, clr_nxt;
  logic [IW-1:0]       ra_r, ra_nxt;
  logic                rv_r, rv_nxt;
  logic [PG_W-1:0]     ci_r, ci_nxt;
  logic [PG_W-1:0]     start_r, start_nxt;
  logic [COUNT_W-1:0]  run_r, run_nxt;
  logic [COUNT_W-1:0]  cnt_r, cnt_nxt;
  logic [63:0]         off_r, off_nxt;
  logic [PG_W-1:0]     wp_r, wp_nxt;
  logic [COUNT_W-1:0]  rem_r, rem_nxt;
  logic                wbit_r, wbit_nxt;
  logic [STATUS_W-1:0] res_status_r, res_status_nxt;
  logic [ADDR_W-1:0]   res_addr_r, res_addr_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic [STATUS_W-1:0] out_status_r, out_status_nxt;
  logic [ADDR_W-1:0]   out_addr_r, out_addr_nxt;

  logic                ram_we;
  logic [PG_W-1:0]     ram_waddr;
  logic                ram_wdata;
  logic [PG_W-1:0]     ram_raddr;
  logic                ram_rdata;

  logic                in_op;
  logic [COUNT_W-1:0]  in_count;
  logic [ADDR_W-1:0]   in_address;
  logic                accept;
  logic                cfg_pc_wr;
  logic [COUNT_W-1:0]  cfg_pc_val;
  logic                alloc_empty, alloc_bad, free_ign;
  logic                can_issue, hit, found, scan_fail;
  logic [COUNT_W-1:0]  run_inc;
  logic [PG_W-1:0]     start_f;
  logic [63:0]         first;
  logic [COUNT_W-1:0]  pc_left;
  logic                f_misaligned, f_bounds;
  logic                post_go;

  assign in_op      = in_tuser[0];
  assign in_count   = in_tdata[COUNT_W-1:0];
  assign in_address = in_tdata[COUNT_W+ADDR_W-1:COUNT_W];
  assign in_tready  = (state_r == S_IDLE);
  assign accept     = in_tvalid && in_tready;

  assign cfg_pc_wr  = cfg_we && (cfg_index == REG_PAGE_COUNT);
  assign cfg_pc_val = (32'(cfg_data[COUNT_W-1:0]) > MAX_PAGES) ? COUNT_W'(MAX_PAGES)
                                                                : cfg_data[COUNT_W-1:0];

  assign alloc_empty = (page_count_r == '0);
  assign alloc_bad   = (in_count == '0) || (in_count > page_count_r);
  assign free_ign    = (in_address == '0) || (in_count == '0);

  assign can_issue = CW'(ra_r) < CW'(page_count_r);
  assign run_inc   = run_r + COUNT_W'(1);
  assign hit       = rv_r && !ram_rdata;
  assign found     = hit && (run_inc == cnt_r);
  assign scan_fail = !rv_r && !can_issue;
  assign start_f   = (run_r == '0) ? ci_r : start_r;

  assign first        = off_r >> PB_LG;
  assign pc_left      = page_count_r - first[COUNT_W-1:0];
  assign f_misaligned = |off_r[PB_LG-1:0];
  assign f_bounds     = (first > 64'(page_count_r)) || (cnt_r > pc_left);

  assign post_go = !out_valid_r || out_tready;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_CLEAR: begin
        if (clr_r == PG_W'(MAX_PAGES - 1)) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (accept) begin
          if (in_op == OP_ALLOC) begin
            state_nxt = (alloc_empty || alloc_bad) ? S_POST : S_SCAN;
          end else begin
            state_nxt = free_ign ? S_POST : S_FCHK;
          end
        end
      end
      S_SCAN: begin
        if (found) state_nxt = S_FILL;
        else if (scan_fail) state_nxt = S_POST;
      end
      S_FCHK: begin
        state_nxt = (f_misaligned || f_bounds) ? S_POST : S_FILL;
      end
      S_FILL: begin
        if (rem_r == COUNT_W'(1)) state_nxt = S_POST;
      end
      S_POST: begin
        if (post_go) state_nxt = S_IDLE;
      end
      default: state_nxt = S_CLEAR;
    endcase
    if (cfg_pc_wr) state_nxt = S_CLEAR;
  end

  always_comb begin
    pool_base_nxt  = pool_base_r;
    page_count_nxt = page_count_r;
    clr_nxt        = clr_r;
    ra_nxt         = ra_r;
    rv_nxt         = rv_r;
    ci_nxt         = ci_r;
    start_nxt      = start_r;
    run_nxt        = run_r;
    cnt_nxt        = cnt_r;
    off_nxt        = off_r;
    wp_nxt         = wp_r;
    rem_nxt        = rem_r;
    wbit_nxt       = wbit_r;
    res_status_nxt = res_status_r;
    res_addr_nxt   = res_addr_r;
    out_valid_nxt  = out_valid_r && !out_tready;
    out_status_nxt = out_status_r;
    out_addr_nxt   = out_addr_r;
    ram_we         = 1'b0;
    ram_waddr      = wp_r;
    ram_wdata      = wbit_r;
    ram_raddr      = ra_r[PG_W-1:0];

    case (state_r)
      S_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_r;
        ram_wdata = 1'b0;
        clr_nxt   = clr_r + PG_W'(1);
      end
      S_IDLE: begin
        if (accept) begin
          cnt_nxt      = in_count;
          res_addr_nxt = '0;
          ra_nxt       = '0;
          rv_nxt       = 1'b0;
          run_nxt      = '0;
          off_nxt      = (64'(in_address) - 64'(pool_base_r)) & ADDR_MASK;
          if (in_op == OP_ALLOC) begin
            if (alloc_empty) res_status_nxt = STAT_POOL_EMPTY;
            else res_status_nxt = STAT_BAD_COUNT;
          end else begin
            res_status_nxt = STAT_IGNORED;
          end
        end
      end
      S_SCAN: begin
        if (can_issue) begin
          ra_nxt = ra_r + IW'(1);
          ci_nxt = ra_r[PG_W-1:0];
        end
        rv_nxt = can_issue;
        if (rv_r) begin
          if (hit) begin
            run_nxt   = run_inc;
            start_nxt = start_f;
          end else begin
            run_nxt = '0;
          end
        end
        if (found) begin
          rv_nxt         = 1'b0;
          wp_nxt         = start_f;
          rem_nxt        = cnt_r;
          wbit_nxt       = 1'b1;
          res_status_nxt = STAT_OK;
          res_addr_nxt   = ADDR_W'(ADDR_MASK & (64'(pool_base_r) + (64'(start_f) << PB_LG)));
        end else if (scan_fail) begin
          res_status_nxt = STAT_NO_RUN;
        end
      end
      S_FCHK: begin
        wp_nxt   = first[PG_W-1:0];
        rem_nxt  = cnt_r;
        wbit_nxt = 1'b0;
        if (f_misaligned) res_status_nxt = STAT_MISALIGNED;
        else if (f_bounds) res_status_nxt = STAT_OUT_BOUNDS;
        else res_status_nxt = STAT_OK;
      end
      S_FILL: begin
        ram_we  = 1'b1;
        wp_nxt  = wp_r + PG_W'(1);
        rem_nxt = rem_r - COUNT_W'(1);
      end
      S_POST: begin
        if (post_go) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = res_status_r;
          out_addr_nxt   = res_addr_r;
        end
      end
      default: ;
    endcase

    if (cfg_we && (cfg_index == REG_POOL_BASE)) pool_base_nxt = cfg_data;
    if (cfg_pc_wr) begin
      page_count_nxt = cfg_pc_val;
      clr_nxt        = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_CLEAR;
      pool_base_r  <= '0;
      page_count_r <= '0;
      clr_r        <= '0;
      rv_r         <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      pool_base_r  <= pool_base_nxt;
      page_count_r <= page_count_nxt;
      clr_r        <= clr_nxt;
      rv_r         <= rv_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ra_r         <= ra_nxt;
    ci_r         <= ci_nxt;
    start_r      <= start_nxt;
    run_r        <= run_nxt;
    cnt_r        <= cnt_nxt;
    off_r        <= off_nxt;
    wp_r         <= wp_nxt;
    rem_r        <= rem_nxt;
    wbit_r       <= wbit_nxt;
    res_status_r <= res_status_nxt;
    res_addr_r   <= res_addr_nxt;
    out_status_r <= out_status_nxt;
    out_addr_r   <= out_addr_nxt;
  end

  bpa_ram #(
    .WIDTH(1),
    .DEPTH(MAX_PAGES)
  ) u_map (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {5'b0, out_addr_r, out_status_r};

endmodule
